>>> rtl/core/fixed_timestep_accumulator_assert.svh
// ----------------------------------------------------------------------------
// Fixed timestep accumulator assertion macros
// Concurrent assertion helpers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef FIXED_TIMESTEP_ACCUMULATOR_ASSERT_SVH
`define FIXED_TIMESTEP_ACCUMULATOR_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define FTA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fta assertion failed");
// Next-cycle implication.
`define FTA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fta assertion failed");
`else
`define FTA_ASSERT_NOW(label, clk, rst, ante, cons)
`define FTA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/core/fta_pkg.sv
// ----------------------------------------------------------------------------
// Fixed timestep accumulator package
// Types and constants shared by the accumulator RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fta_pkg;

   // Width of the working interval; wide enough for elapsed plus leftover
   // minus one more step.
   localparam int ACC_W  = 36;
   localparam int SLOP_W = 34;

   localparam logic [SLOP_W-1:0] SLOP_MAX = 34'h1_FFFF_FFFF;
   localparam logic [SLOP_W-1:0] SLOP_MIN = 34'h2_0000_0000;

   localparam logic [31:0] STEP_RESET = 32'd16667;
   localparam logic [30:0] TOL_RESET  = 31'd0;

   // Register index, taken from address bit 2.
   localparam logic REG_STEP_INTERVAL = 1'b0;
   localparam logic REG_TOLERANCE     = 1'b1;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_RUN    = 2'd1,
      OP_PAUSE  = 2'd2,
      OP_RESUME = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOOP,
      ST_FIX,
      ST_SAT,
      ST_FINISH
   } state_type;

endpackage

>>> rtl/core/fixed_timestep_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed timestep accumulator
// Counts the fixed simulation steps due for each frame from a free-running
// tick timestamp, with start, pause and resume handling.
// ----------------------------------------------------------------------------
// Each item carries an operation (start, run, pause, resume) and a timestamp
// in ticks, and produces exactly one result item: the number of steps due,
// the paused flag after the item, and an overrun flag when the count was
// capped at MAX_STEPS. The block works on one item at a time and holds
// req_stall high until that item is finished. Start, pause, resume and a run
// while paused go from decode to finish. A run goes through the step loop,
// where a single 36-bit subtractor takes off one step interval per cycle,
// then fix-up when the interval drops below a step, saturation and finish.
// The result sits in an output register, so the next item can be accepted
// while the previous result is still waiting on rsp_stall. The step interval
// and tolerance are written through the APB port at byte addresses 0 and 4.
// ----------------------------------------------------------------------------

`include "fixed_timestep_accumulator_assert.svh"

module fixed_timestep_accumulator #(
   parameter int MAX_STEPS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_timestamp,
   // result item channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_step_count,
   output logic        rsp_is_paused,
   output logic        rsp_overrun,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int          ACC_W     = fta_pkg::ACC_W;
   localparam int          SLOP_W    = fta_pkg::SLOP_W;
   localparam logic [6:0]  MAX_COUNT = 7'(MAX_STEPS);

   // Sequencer and item registers
   fta_pkg::state_type state_ff, state_in;
   fta_pkg::op_type    op_ff, op_in;
   logic [31:0]        time_ff, time_in;

   // Configuration
   logic [31:0] step_ff, step_in;
   logic [30:0] tol_ff, tol_in;

   // Architectural state
   logic [31:0]       last_time_ff, last_time_in;
   logic [SLOP_W-1:0] slop_ff, slop_in;
   logic              paused_ff, paused_in;
   logic [31:0]       pause_time_ff, pause_time_in;

   // Working registers of the step loop
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [6:0]       count_ff, count_in;
   logic             over_ff, over_in;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] rsp_step_count_ff, rsp_step_count_in;
   logic       rsp_is_paused_ff, rsp_is_paused_in;
   logic       rsp_overrun_ff, rsp_overrun_in;

   logic             req_accept;
   logic             csr_write;
   logic             rsp_free;
   logic [31:0]      elapsed;
   logic [ACC_W-1:0] diff;
   logic [ACC_W-1:0] tol_ext;
   logic [ACC_W-1:0] diff_plus_tol;
   logic             diff_neg;
   logic             diff_le_tol;
   logic             near_step;

   assign req_stall  = (state_ff != fta_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_step_count = rsp_step_count_ff;
   assign rsp_is_paused  = rsp_is_paused_ff;
   assign rsp_overrun    = rsp_overrun_ff;

   // The shared unit: the working interval minus one step. Both tolerance
   // tests are made against this difference, so the interval is never
   // compared against step plus or minus tolerance directly.
   assign elapsed       = time_ff - last_time_ff;
   assign diff          = acc_ff - {4'b0, step_ff};
   assign tol_ext       = {5'b0, tol_ff};
   assign diff_plus_tol = diff + tol_ext;
   assign diff_neg      = diff[ACC_W-1];
   assign diff_le_tol   = $signed(diff) <= $signed(tol_ext);
   assign near_step     = !diff_plus_tol[ACC_W-1];

   // ------------------------------------------------------------------------
   // Configuration port. Address bit 2 picks the register; writes happen in
   // the access phase and reads return the current value.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      step_in    = step_ff;
      tol_in     = tol_ff;
      csr_prdata = step_ff;
      unique case (csr_paddr[2])
         fta_pkg::REG_STEP_INTERVAL: begin
            csr_prdata = step_ff;
            if (csr_write) begin
               step_in = csr_pwdata;
            end
         end
         fta_pkg::REG_TOLERANCE: begin
            csr_prdata = {1'b0, tol_ff};
            if (csr_write) begin
               tol_in = csr_pwdata[30:0];
            end
         end
         default: begin
            csr_prdata = step_ff;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer next state. A run goes through the loop, which takes one step
   // per cycle until the interval drops below a step, the tolerance lets a
   // second step be skipped, or the cap is reached. The fix-up state then
   // takes one step that is nearly due when none was counted.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fta_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = fta_pkg::ST_DECODE;
            end
         end
         fta_pkg::ST_DECODE: begin
            if (op_ff == fta_pkg::OP_RUN && !paused_ff) begin
               state_in = fta_pkg::ST_LOOP;
            end else begin
               state_in = fta_pkg::ST_FINISH;
            end
         end
         fta_pkg::ST_LOOP: begin
            if (diff_neg) begin
               state_in = fta_pkg::ST_FIX;
            end else if ((count_ff == 7'd1 && diff_le_tol) || count_ff >= MAX_COUNT) begin
               state_in = fta_pkg::ST_SAT;
            end
         end
         fta_pkg::ST_FIX: begin
            state_in = fta_pkg::ST_SAT;
         end
         fta_pkg::ST_SAT: begin
            state_in = fta_pkg::ST_FINISH;
         end
         fta_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = fta_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fta_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer outputs and datapath updates.
   // ------------------------------------------------------------------------
   always_comb begin
      op_in             = op_ff;
      time_in           = time_ff;
      last_time_in      = last_time_ff;
      slop_in           = slop_ff;
      paused_in         = paused_ff;
      pause_time_in     = pause_time_ff;
      acc_in            = acc_ff;
      count_in          = count_ff;
      over_in           = over_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_step_count_in = rsp_step_count_ff;
      rsp_is_paused_in  = rsp_is_paused_ff;
      rsp_overrun_in    = rsp_overrun_ff;

      unique case (state_ff)
         fta_pkg::ST_IDLE: begin
            if (req_accept) begin
               op_in   = fta_pkg::op_type'(req_op);
               time_in = req_timestamp;
            end
         end
         fta_pkg::ST_DECODE: begin
            count_in = 7'd0;
            over_in  = 1'b0;
            case (op_ff)
               fta_pkg::OP_START: begin
                  last_time_in = time_ff;
                  slop_in      = '0;
                  paused_in    = 1'b0;
               end
               fta_pkg::OP_RUN: begin
                  if (!paused_ff) begin
                     acc_in       = {4'b0, elapsed} + {{2{slop_ff[SLOP_W-1]}}, slop_ff};
                     last_time_in = time_ff;
                  end
               end
               fta_pkg::OP_PAUSE: begin
                  if (!paused_ff) begin
                     paused_in     = 1'b1;
                     pause_time_in = time_ff;
                  end
               end
               fta_pkg::OP_RESUME: begin
                  if (paused_ff) begin
                     // Push the last time forward by the paused span.
                     paused_in    = 1'b0;
                     last_time_in = last_time_ff + (time_ff - pause_time_ff);
                  end
               end
               default: begin
                  paused_in = paused_ff;
               end
            endcase
         end
         fta_pkg::ST_LOOP: begin
            if (!diff_neg && !(count_ff == 7'd1 && diff_le_tol)) begin
               if (count_ff >= MAX_COUNT) begin
                  over_in = 1'b1;
               end else begin
                  count_in = count_ff + 7'd1;
                  acc_in   = diff;
               end
            end
         end
         fta_pkg::ST_FIX: begin
            if (count_ff == 7'd0 && near_step) begin
               count_in = 7'd1;
               acc_in   = diff;
            end
         end
         fta_pkg::ST_SAT: begin
            // The leftover fits when the top three bits agree.
            if (acc_ff[ACC_W-1:SLOP_W-1] == 3'b000 || acc_ff[ACC_W-1:SLOP_W-1] == 3'b111) begin
               slop_in = acc_ff[SLOP_W-1:0];
            end else if (acc_ff[ACC_W-1]) begin
               slop_in = fta_pkg::SLOP_MIN;
            end else begin
               slop_in = fta_pkg::SLOP_MAX;
            end
         end
         fta_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in      = 1'b1;
               rsp_step_count_in = count_ff;
               rsp_is_paused_in  = paused_ff;
               rsp_overrun_in    = over_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Registers. Control and architectural state reset; item payload and loop
   // working registers are always written before use.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fta_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         step_ff       <= fta_pkg::STEP_RESET;
         tol_ff        <= fta_pkg::TOL_RESET;
         last_time_ff  <= '0;
         slop_ff       <= '0;
         paused_ff     <= 1'b0;
         pause_time_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         step_ff       <= step_in;
         tol_ff        <= tol_in;
         last_time_ff  <= last_time_in;
         slop_ff       <= slop_in;
         paused_ff     <= paused_in;
         pause_time_ff <= pause_time_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff             <= op_in;
      time_ff           <= time_in;
      acc_ff            <= acc_in;
      count_ff          <= count_in;
      over_ff           <= over_in;
      rsp_step_count_ff <= rsp_step_count_in;
      rsp_is_paused_ff  <= rsp_is_paused_in;
      rsp_overrun_ff    <= rsp_overrun_in;
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // An accepted item always moves the sequencer into decode.
   `FTA_ASSERT_NEXT(a_accept_decodes, clock, reset, req_accept, state_ff == fta_pkg::ST_DECODE)
   // The loop never counts past the cap.
   `FTA_ASSERT_NOW(a_count_capped, clock, reset, state_ff == fta_pkg::ST_LOOP, count_ff <= MAX_COUNT)
   // An overrun result always carries the full step count.
   `FTA_ASSERT_NOW(a_overrun_full, clock, reset, rsp_valid && rsp_overrun, rsp_step_count == MAX_COUNT)
   // While paused no steps are reported.
   `FTA_ASSERT_NOW(a_paused_no_steps, clock, reset, rsp_valid && rsp_is_paused, rsp_step_count == 7'd0)

endmodule
